@@ hw/rtl/wsbc_pkg.sv @@
// Shared types and constants for the wall segment / box collision pipeline.
// Depends on nothing; wsbc_clip_side, the top level and the testbench import it.
package wsbc_pkg;

   // Input word: one wall segment, signed fixed point.
   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
   } req_type;

   // Result word.
   typedef struct packed {
      logic       hit;
      logic [1:0] hit_cause;
   } rsp_type;

   localparam logic [1:0] CAUSE_NONE  = 2'd0;
   localparam logic [1:0] CAUSE_CROSS = 2'd1;
   localparam logic [1:0] CAUSE_BAND  = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_BOX_MIN_X  = 3'd0;
   localparam logic [2:0] REG_BOX_MIN_Y  = 3'd1;
   localparam logic [2:0] REG_BOX_MAX_X  = 3'd2;
   localparam logic [2:0] REG_BOX_MAX_Y  = 3'd3;
   localparam logic [2:0] REG_WALL_THICK = 3'd4;

   // One clip boundary: candidate parameter rn/rd and the sign class of p.
   typedef struct packed {
      logic signed [32:0] rn;
      logic signed [32:0] rd;
      logic               pneg;
      logic               pzero;
      logic               qnn;
   } side_type;

   // Running clip interval t = tn/td, u = un/ud.
   typedef struct packed {
      logic               pass;
      logic signed [32:0] tn;
      logic signed [32:0] td;
      logic signed [32:0] un;
      logic signed [32:0] ud;
   } clip_type;

   localparam clip_type CLIP_INIT = '{pass: 1'b1, tn: 33'sd0, td: 33'sd1,
                                      un: 33'sd1, ud: 33'sd1};

   // Per-corner sign and range flags that travel beside the square products.
   typedef struct packed {
      logic a_neg;
      logic a_big;
      logic e_nn;
      logic e_big;
      logic c_big;
   } band_flag_type;

endpackage

@@ hw/rtl/wsbc_mul.sv @@
// Two-stage signed multiplier built from 32-bit limbs.
// Depends on nothing; used by the clip stages and the corner band test.
module wsbc_mul #(
   parameter int AW = 33,
   parameter int BW = 33
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [AW-1:0]     a,
   input  logic signed [BW-1:0]     b,
   output logic signed [AW+BW-1:0]  p
);

   localparam int PW = AW + BW;
   localparam int HA = AW - 32;
   localparam int HB = BW - 32;

   logic signed [65:0]      ll_ff, ll_in;
   logic signed [HB+32:0]   lh_ff, lh_in;
   logic signed [HA+32:0]   hl_ff, hl_in;
   logic signed [HA+HB-1:0] hh_ff, hh_in;
   logic signed [PW-1:0]    p_ff, p_in;

   // The low limbs are unsigned, the high limbs carry the sign.
   assign ll_in = $signed({1'b0, a[31:0]}) * $signed({1'b0, b[31:0]});
   assign lh_in = $signed({1'b0, a[31:0]}) * $signed(b[BW-1:32]);
   assign hl_in = $signed(a[AW-1:32]) * $signed({1'b0, b[31:0]});
   assign hh_in = $signed(a[AW-1:32]) * $signed(b[BW-1:32]);

   assign p_in = (PW'(hh_ff) <<< 64) + (PW'(lh_ff) <<< 32) + (PW'(hl_ff) <<< 32)
               + PW'(ll_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         hh_ff <= hh_in;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;

endmodule

@@ hw/rtl/wsbc_clip_side.sv @@
// One boundary of the segment clip: four cross products and the interval update.
// Depends on wsbc_pkg and wsbc_mul; the output is registered after the multipliers.
module wsbc_clip_side
   import wsbc_pkg::*;
#(
   parameter int SIDE = 0
) (
   input  logic            clock,
   input  logic            en,
   input  clip_type        clip_prev,
   input  side_type [3:0]  sides_prev,
   output clip_type        clip_next,
   output side_type [3:0]  sides_next
);

   localparam logic [1:0] SEL = 2'(SIDE);

   side_type           cur;
   side_type           sd;
   logic signed [65:0] p_ru, p_ur, p_rt, p_tr;
   clip_type           clip_d1_ff, clip_d2_ff, clip_ff, clip_ff_in;
   side_type [3:0]     sides_d1_ff, sides_d2_ff, sides_ff;

   assign cur = sides_prev[SEL];

   wsbc_mul #(.AW(33), .BW(33)) u_mul_ru (
      .clock(clock), .en(en), .a(cur.rn), .b(clip_prev.ud), .p(p_ru));
   wsbc_mul #(.AW(33), .BW(33)) u_mul_ur (
      .clock(clock), .en(en), .a(clip_prev.un), .b(cur.rd), .p(p_ur));
   wsbc_mul #(.AW(33), .BW(33)) u_mul_rt (
      .clock(clock), .en(en), .a(cur.rn), .b(clip_prev.td), .p(p_rt));
   wsbc_mul #(.AW(33), .BW(33)) u_mul_tr (
      .clock(clock), .en(en), .a(clip_prev.tn), .b(cur.rd), .p(p_tr));

   assign sd = sides_d2_ff[SEL];

   // Fractions are compared by cross multiplication; all denominators are positive.
   always_comb begin
      clip_ff_in = clip_d2_ff;
      if (clip_d2_ff.pass) begin
         if (sd.pzero) begin
            clip_ff_in.pass = sd.qnn;
         end else if (sd.pneg) begin
            if (p_ru > p_ur) begin
               clip_ff_in.pass = 1'b0;
            end else if (p_rt > p_tr) begin
               clip_ff_in.tn = sd.rn;
               clip_ff_in.td = sd.rd;
            end
         end else begin
            if (p_tr > p_rt) begin
               clip_ff_in.pass = 1'b0;
            end else if (p_ur > p_ru) begin
               clip_ff_in.un = sd.rn;
               clip_ff_in.ud = sd.rd;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         clip_d1_ff  <= clip_prev;
         clip_d2_ff  <= clip_d1_ff;
         clip_ff     <= clip_ff_in;
         sides_d1_ff <= sides_prev;
         sides_d2_ff <= sides_d1_ff;
         sides_ff    <= sides_d2_ff;
      end
   end

   assign clip_next  = clip_ff;
   assign sides_next = sides_ff;

endmodule

@@ hw/rtl/wall_segment_box_collision.sv @@
// Top level: wall segment against shrunk box, clip test and corner band test.
// Depends on wsbc_pkg, wsbc_mul and wsbc_clip_side.
//
// Usage: write the box bounds and the wall thickness over the csr_ port while
// the block is idle. Then stream wall segments on req_ (one word per cycle);
// each accepted word yields exactly one result word on rsp_, in order.
// Throughput is one word per clock while the receiver does not stall a
// waiting result. The pipeline depth is set by the four clip boundaries,
// which depend on each other, each a two-stage multiplier and an interval
// update; the corner band test runs beside them and waits at the end.
// Reset clears the configuration registers to zero and empties the pipeline;
// no word is taken while reset is high. When the receiver stalls a waiting
// result, the whole pipeline holds and req_stall rises until the result is
// taken; nothing is lost or repeated. The OR over a list of walls is up to
// the receiver.
module wall_segment_box_collision
   import wsbc_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic signed [32:0] UNIT = 33'sd1 <<< COORD_FRAC_BITS;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v > 33'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -33'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic side_type make_side(input logic signed [32:0] q,
                                          input logic signed [32:0] nq,
                                          input logic pneg, input logic pzero,
                                          input logic signed [32:0] pmag);
      side_type s;
      s.pneg  = pneg;
      s.pzero = pzero;
      s.rn    = pneg ? nq : q;
      s.rd    = pmag;
      s.qnn   = !q[32];
      return s;
   endfunction

   // ---------------- configuration ----------------
   logic signed [31:0] box_min_x_ff, box_min_y_ff, box_max_x_ff, box_max_y_ff;
   logic [30:0]        thick_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_x_ff <= '0;
         box_min_y_ff <= '0;
         box_max_x_ff <= '0;
         box_max_y_ff <= '0;
         thick_ff     <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            REG_BOX_MIN_X:  box_min_x_ff <= csr_pwdata;
            REG_BOX_MIN_Y:  box_min_y_ff <= csr_pwdata;
            REG_BOX_MAX_X:  box_max_x_ff <= csr_pwdata;
            REG_BOX_MAX_Y:  box_max_y_ff <= csr_pwdata;
            REG_WALL_THICK: thick_ff     <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_BOX_MIN_X:  csr_prdata = box_min_x_ff;
         REG_BOX_MIN_Y:  csr_prdata = box_min_y_ff;
         REG_BOX_MAX_X:  csr_prdata = box_max_x_ff;
         REG_BOX_MAX_Y:  csr_prdata = box_max_y_ff;
         REG_WALL_THICK: csr_prdata = {1'b0, thick_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // Shrunk box and squared thickness follow the registers in the next cycle.
   logic signed [31:0] lx_ff, ly_ff, hx_ff, hy_ff;
   logic [61:0]        w2_ff;

   always_ff @(posedge clock) begin
      lx_ff <= sat32(33'(box_min_x_ff) + UNIT);
      ly_ff <= sat32(33'(box_min_y_ff) + UNIT);
      hx_ff <= sat32(33'(box_max_x_ff) - UNIT);
      hy_ff <= sat32(33'(box_max_y_ff) - UNIT);
      w2_ff <= 62'(thick_ff) * 62'(thick_ff);
   end

   // ---------------- pipeline control ----------------
   logic        en;
   logic [13:0] vld_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff, rsp_data_in;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[12:0], req_valid};
         rsp_valid_ff <= vld_ff[13];
      end
   end

   // ---------------- stage 0: capture and direction ----------------
   logic signed [31:0] sx0_ff, sy0_ff;
   logic signed [32:0] dx0_ff, dy0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sx0_ff <= req_data.start_x;
         sy0_ff <= req_data.start_y;
         dx0_ff <= 33'(req_data.end_x) - 33'(req_data.start_x);
         dy0_ff <= 33'(req_data.end_y) - 33'(req_data.start_y);
      end
   end

   // ---------------- stage 1: clip boundaries and corner offsets ----------------
   logic signed [32:0] adx, ady;
   side_type [3:0]     sides1_in, sides1_ff;
   logic signed [32:0] dx1_ff, dy1_ff;
   logic signed [32:0] ex1_ff [0:3];
   logic signed [32:0] ey1_ff [0:3];
   logic [7:1]         lz_ff;

   assign adx = dx0_ff[32] ? -dx0_ff : dx0_ff;
   assign ady = dy0_ff[32] ? -dy0_ff : dy0_ff;

   // Boundaries in order: left (p = -dx), right (p = dx), bottom, top.
   always_comb begin
      sides1_in[0] = make_side(33'(sx0_ff) - 33'(lx_ff), 33'(lx_ff) - 33'(sx0_ff),
                               !dx0_ff[32] && dx0_ff != '0, dx0_ff == '0, adx);
      sides1_in[1] = make_side(33'(hx_ff) - 33'(sx0_ff), 33'(sx0_ff) - 33'(hx_ff),
                               dx0_ff[32], dx0_ff == '0, adx);
      sides1_in[2] = make_side(33'(sy0_ff) - 33'(ly_ff), 33'(ly_ff) - 33'(sy0_ff),
                               !dy0_ff[32] && dy0_ff != '0, dy0_ff == '0, ady);
      sides1_in[3] = make_side(33'(hy_ff) - 33'(sy0_ff), 33'(sy0_ff) - 33'(hy_ff),
                               dy0_ff[32], dy0_ff == '0, ady);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sides1_ff <= sides1_in;
         dx1_ff    <= dx0_ff;
         dy1_ff    <= dy0_ff;
         lz_ff     <= {lz_ff[6:1], (dx0_ff == '0) && (dy0_ff == '0)};
      end
   end

   // ---------------- clip chain: stages 2 to 13 ----------------
   clip_type       clip_s [0:4];
   side_type [3:0] sides_s [0:4];

   assign clip_s[0]  = CLIP_INIT;
   assign sides_s[0] = sides1_ff;

   for (genvar s = 0; s < 4; s++) begin : g_side
      wsbc_clip_side #(.SIDE(s)) u_side (
         .clock(clock), .en(en),
         .clip_prev(clip_s[s]), .sides_prev(sides_s[s]),
         .clip_next(clip_s[s+1]), .sides_next(sides_s[s+1]));
   end

   // ---------------- corner band test: stages 2 to 8 ----------------
   logic signed [65:0]  mxx, myy;
   logic [64:0]         l2_4_ff;
   logic signed [128:0] k6, k7_ff;
   logic signed [66:0]  a4_ff [0:3];
   logic signed [66:0]  c4_ff [0:3];
   band_flag_type       fl5_ff [0:3];
   band_flag_type       fl6_ff [0:3];
   band_flag_type       fl7_ff [0:3];
   logic [63:0]         alo5_ff [0:3];
   logic [63:0]         elo5_ff [0:3];
   logic [63:0]         clo5_ff [0:3];
   logic [3:0]          corner_hit;
   logic [13:8]         any_ff;

   wsbc_mul #(.AW(33), .BW(33)) u_mul_xx (
      .clock(clock), .en(en), .a(dx1_ff), .b(dx1_ff), .p(mxx));
   wsbc_mul #(.AW(33), .BW(33)) u_mul_yy (
      .clock(clock), .en(en), .a(dy1_ff), .b(dy1_ff), .p(myy));

   // k = (L * W)^2 against which twice the along and across distances are squared.
   wsbc_mul #(.AW(66), .BW(63)) u_mul_k (
      .clock(clock), .en(en), .a($signed({1'b0, l2_4_ff})),
      .b($signed({1'b0, w2_ff})), .p(k6));

   always_ff @(posedge clock) begin
      if (en) begin
         l2_4_ff <= 65'(66'(mxx) + 66'(myy));
         k7_ff   <= k6;
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_corner
      logic signed [31:0]  cx, cy;
      logic signed [65:0]  m_ad, m_bd, m_cx, m_cy;
      logic signed [67:0]  na, d, cab;
      logic [66:0]         amag, emag, cmag;
      band_flag_type       fl5_in;
      logic signed [129:0] sqa, sqe, sqc;
      logic                sk_a, sk_e, in_band;

      assign cx = i[1] ? hx_ff : lx_ff;
      assign cy = i[0] ? hy_ff : ly_ff;

      always_ff @(posedge clock) begin
         if (en) begin
            ex1_ff[i] <= 33'(cx) - 33'(sx0_ff);
            ey1_ff[i] <= 33'(cy) - 33'(sy0_ff);
         end
      end

      wsbc_mul #(.AW(33), .BW(33)) u_mul_ad (
         .clock(clock), .en(en), .a(ex1_ff[i]), .b(dx1_ff), .p(m_ad));
      wsbc_mul #(.AW(33), .BW(33)) u_mul_bd (
         .clock(clock), .en(en), .a(ey1_ff[i]), .b(dy1_ff), .p(m_bd));
      wsbc_mul #(.AW(33), .BW(33)) u_mul_cx (
         .clock(clock), .en(en), .a(ex1_ff[i]), .b(dy1_ff), .p(m_cx));
      wsbc_mul #(.AW(33), .BW(33)) u_mul_cy (
         .clock(clock), .en(en), .a(ey1_ff[i]), .b(dx1_ff), .p(m_cy));

      // Doubled values: -2a, 2a - 2L^2 and 2|c|, split into a 64-bit part and
      // a flag for anything larger, whose square is then above k anyway.
      assign na   = -68'(a4_ff[i]);
      assign d    = 68'(a4_ff[i]) - 68'($signed({1'b0, l2_4_ff}));
      assign cab  = c4_ff[i][66] ? -68'(c4_ff[i]) : 68'(c4_ff[i]);
      assign amag = {na[65:0], 1'b0};
      assign emag = {d[65:0], 1'b0};
      assign cmag = {cab[65:0], 1'b0};

      always_comb begin
         fl5_in.a_neg = a4_ff[i][66];
         fl5_in.a_big = amag[66:64] != '0;
         fl5_in.e_nn  = !d[67];
         fl5_in.e_big = emag[66:64] != '0;
         fl5_in.c_big = cmag[66:64] != '0;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            a4_ff[i]   <= 67'(m_ad) + 67'(m_bd);
            c4_ff[i]   <= 67'(m_cx) - 67'(m_cy);
            fl5_ff[i]  <= fl5_in;
            alo5_ff[i] <= amag[63:0];
            elo5_ff[i] <= emag[63:0];
            clo5_ff[i] <= cmag[63:0];
            fl6_ff[i]  <= fl5_ff[i];
            fl7_ff[i]  <= fl6_ff[i];
         end
      end

      wsbc_mul #(.AW(65), .BW(65)) u_mul_sqa (
         .clock(clock), .en(en), .a($signed({1'b0, alo5_ff[i]})),
         .b($signed({1'b0, alo5_ff[i]})), .p(sqa));
      wsbc_mul #(.AW(65), .BW(65)) u_mul_sqe (
         .clock(clock), .en(en), .a($signed({1'b0, elo5_ff[i]})),
         .b($signed({1'b0, elo5_ff[i]})), .p(sqe));
      wsbc_mul #(.AW(65), .BW(65)) u_mul_sqc (
         .clock(clock), .en(en), .a($signed({1'b0, clo5_ff[i]})),
         .b($signed({1'b0, clo5_ff[i]})), .p(sqc));

      // Skip the corner beyond either end of the band; hit when strictly inside.
      assign sk_a    = fl7_ff[i].a_neg && (fl7_ff[i].a_big || sqa > 130'(k7_ff));
      assign sk_e    = fl7_ff[i].e_nn && (fl7_ff[i].e_big || sqe > 130'(k7_ff));
      assign in_band = !fl7_ff[i].c_big && (sqc < 130'(k7_ff));

      // A zero-length wall has no direction; each corner hits on a nonzero thickness.
      assign corner_hit[i] = lz_ff[7] ? (thick_ff != '0) : (!sk_a && !sk_e && in_band);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         any_ff <= {any_ff[12:8], |corner_hit};
      end
   end

   // ---------------- stage 14: result register ----------------
   always_comb begin
      if (clip_s[4].pass) begin
         rsp_data_in.hit       = 1'b1;
         rsp_data_in.hit_cause = CAUSE_CROSS;
      end else if (any_ff[13]) begin
         rsp_data_in.hit       = 1'b1;
         rsp_data_in.hit_cause = CAUSE_BAND;
      end else begin
         rsp_data_in.hit       = 1'b0;
         rsp_data_in.hit_cause = CAUSE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for wall_segment_box_collision: segment clip and corner band test.
// Depends on wsbc_pkg and the wall_segment_box_collision RTL; needs nothing else to run.
`timescale 1ns / 1ps

module testbench;
   import wsbc_pkg::*;

   localparam longint UNIT      = 256;
   localparam int     WDOG_MAX  = 5000;
   localparam int     DRAIN_GAP = 20;
   localparam int     N_BLOCKS  = 14;
   localparam int     BLOCK_LEN = 100;

   typedef logic signed [129:0] wide_type;

   typedef struct {
      bit          is_cfg;
      logic [2:0]  reg_idx;
      logic [31:0] reg_val;
      req_type     wall;
      bit          has_exp;
      rsp_type     exp;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow copy of the box and thickness registers.
   logic signed [31:0] box_lo_x, box_lo_y, box_hi_x, box_hi_y;
   logic [30:0]        thick;

   rsp_type     pending_hits[$];
   dir_row_type dir_rows[$];
   int          fails, walls_sent, results_seen, cross_seen, band_seen;
   int          tx_idle_pct, rx_idle_pct, quiet_cycles;

   wall_segment_box_collision u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic bit ratio_gt(longint an, longint ad, longint bn, longint bd);
      return (wide_type'(an) * wide_type'(bd)) > (wide_type'(bn) * wide_type'(ad));
   endfunction

   // One Liang-Barsky boundary; narrows the interval [tn/td, un/ud].
   function automatic bit clip_edge(input longint p, input longint q, inout longint tn,
                                    inout longint td, inout longint un, inout longint ud);
      longint rn, rd;
      if (p == 0) return q >= 0;
      rn = (p < 0) ? -q : q;
      rd = (p < 0) ? -p : p;
      if (p < 0) begin
         if (ratio_gt(rn, rd, un, ud)) return 0;
         if (ratio_gt(rn, rd, tn, td)) begin
            tn = rn;
            td = rd;
         end
      end else begin
         if (ratio_gt(tn, td, rn, rd)) return 0;
         if (ratio_gt(un, ud, rn, rd)) begin
            un = rn;
            ud = rd;
         end
      end
      return 1;
   endfunction

   // Compares v*v with k; v is nonnegative.
   function automatic int square_cmp(wide_type v, logic [127:0] k);
      logic [127:0] sq;
      if (v >= (wide_type'(1) <<< 64)) return 1;
      sq = 128'(v[63:0]) * 128'(v[63:0]);
      if (sq > k) return 1;
      if (sq < k) return -1;
      return 0;
   endfunction

   function automatic bit corner_in_band(longint cx, longint cy, longint sx, longint sy,
                                         longint dx, longint dy, wide_type l2,
                                         logic [127:0] k);
      longint   ex, ey;
      wide_type a2, e, c;
      ex = cx - sx;
      ey = cy - sy;
      if (l2 == 0) return thick != 0;
      a2 = (wide_type'(ex) * wide_type'(dx) + wide_type'(ey) * wide_type'(dy)) * 2;
      if (a2 < 0 && square_cmp(-a2, k) > 0) return 0;
      e = a2 - l2 * 2;
      if (e >= 0 && square_cmp(e, k) > 0) return 0;
      c = wide_type'(ex) * wide_type'(dy) - wide_type'(ey) * wide_type'(dx);
      if (c < 0) c = -c;
      return square_cmp(c * 2, k) < 0;
   endfunction

   function automatic rsp_type collide_wall(req_type w);
      longint       sx, sy, dx, dy, lx, ly, hx, hy, tn, td, un, ud;
      wide_type     l2;
      logic [127:0] k;
      rsp_type      r;
      sx = w.start_x;
      sy = w.start_y;
      dx = longint'(w.end_x) - sx;
      dy = longint'(w.end_y) - sy;
      lx = sat32(longint'(box_lo_x) + UNIT);
      ly = sat32(longint'(box_lo_y) + UNIT);
      hx = sat32(longint'(box_hi_x) - UNIT);
      hy = sat32(longint'(box_hi_y) - UNIT);
      tn = 0; td = 1; un = 1; ud = 1;
      r.hit_cause = CAUSE_NONE;
      if (clip_edge(-dx, sx - lx, tn, td, un, ud) && clip_edge(dx, hx - sx, tn, td, un, ud) &&
          clip_edge(-dy, sy - ly, tn, td, un, ud) && clip_edge(dy, hy - sy, tn, td, un, ud))
      begin
         r.hit_cause = CAUSE_CROSS;
      end else begin
         l2 = wide_type'(dx) * wide_type'(dx) + wide_type'(dy) * wide_type'(dy);
         k = 128'(l2[127:0]) * 128'(64'(thick) * 64'(thick));
         if (corner_in_band(lx, ly, sx, sy, dx, dy, l2, k) ||
             corner_in_band(lx, hy, sx, sy, dx, dy, l2, k) ||
             corner_in_band(hx, ly, sx, sy, dx, dy, l2, k) ||
             corner_in_band(hx, hy, sx, sy, dx, dy, l2, k))
            r.hit_cause = CAUSE_BAND;
      end
      r.hit = (r.hit_cause != CAUSE_NONE);
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   // Every write ends by waiting with csr_psel low, so back-to-back writes never meet
   // in the same time step.
   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_BOX_MIN_X:  box_lo_x = val;
         REG_BOX_MIN_Y:  box_lo_y = val;
         REG_BOX_MAX_X:  box_hi_x = val;
         REG_BOX_MAX_Y:  box_hi_y = val;
         REG_WALL_THICK: thick    = val[30:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic box_write(logic [31:0] lx, logic [31:0] ly, logic [31:0] hx,
                            logic [31:0] hy, logic [31:0] w);
      csr_write(REG_BOX_MIN_X, lx);
      csr_write(REG_BOX_MIN_Y, ly);
      csr_write(REG_BOX_MAX_X, hx);
      csr_write(REG_BOX_MAX_Y, hy);
      csr_write(REG_WALL_THICK, w);
   endtask

   // Sends one word; req_valid then stays high until the caller or a later call changes it.
   task automatic send_wall(req_type w, bit has_exp, rsp_type exp);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      pending_hits.push_back(has_exp ? exp : collide_wall(w));
      walls_sent++;
   endtask

   task automatic row_wall(int sx, int sy, int ex, int ey, bit has_exp, logic [1:0] cause);
      dir_row_type r;
      r.is_cfg      = 0;
      r.wall        = '{start_x: sx, start_y: sy, end_x: ex, end_y: ey};
      r.has_exp     = has_exp;
      r.exp.hit       = (cause != CAUSE_NONE);
      r.exp.hit_cause = cause;
      dir_rows.push_back(r);
   endtask

   task automatic row_cfg(logic [2:0] idx, logic [31:0] val);
      dir_row_type r;
      r.is_cfg  = 1;
      r.reg_idx = idx;
      r.reg_val = val;
      dir_rows.push_back(r);
   endtask

   function automatic int near_coord(int center, int span);
      return center + int'($urandom_range(2 * span)) - span;
   endfunction

   // Result checking, receiver stalls and the watchdog.
   always @(posedge clock) begin
      rsp_type exp;
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WDOG_MAX) begin
            $display("watchdog: no activity for %0d cycles", WDOG_MAX);
            $display("wall_segment_box_collision: mismatch");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_hits.size() == 0) begin
               $error("result word with nothing expected");
               fails++;
            end else begin
               exp = pending_hits.pop_front();
               if (rsp_data.hit !== exp.hit) begin
                  $error("hit: expected %0d, got %0d", exp.hit, rsp_data.hit);
                  fails++;
               end
               if (rsp_data.hit_cause !== exp.hit_cause) begin
                  $error("hit_cause: expected %0d, got %0d", exp.hit_cause, rsp_data.hit_cause);
                  fails++;
               end
               if (exp.hit_cause == CAUSE_CROSS) cross_seen++;
               if (exp.hit_cause == CAUSE_BAND) band_seen++;
            end
         end
      end
   end

   initial begin
      int      bx, by, sz, span, wt;
      req_type w;
      rsp_type none;
      none = '0;
      fails = 0; walls_sent = 0; results_seen = 0; cross_seen = 0; band_seen = 0;
      quiet_cycles = 0;
      tx_idle_pct = 31;
      rx_idle_pct = 57;
      box_lo_x = 0; box_lo_y = 0; box_hi_x = 0; box_hi_y = 0; thick = 0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      rsp_stall   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // After reset the shrunk box is inverted and the thickness is zero.
      row_wall(0, 0, 0, 0, 1, CAUSE_NONE);
      row_wall(-2147483648, -2147483648, 2147483647, 2147483647, 0, CAUSE_NONE);
      row_cfg(REG_BOX_MIN_X, 0);
      row_cfg(REG_BOX_MIN_Y, 0);
      row_cfg(REG_BOX_MAX_X, 2560);
      row_cfg(REG_BOX_MAX_Y, 2560);
      row_cfg(REG_WALL_THICK, 512);
      row_wall(0, 1280, 2560, 1280, 1, CAUSE_CROSS);
      row_wall(1000, 1000, 1200, 1200, 1, CAUSE_CROSS);
      row_wall(10000, 10000, 20000, 10000, 1, CAUSE_NONE);
      row_wall(100000, 100000, 100000, 100000, 1, CAUSE_BAND);
      row_wall(0, 2400, 2560, 2400, 0, CAUSE_NONE);
      row_wall(2000, 2560, 2560, 2000, 0, CAUSE_NONE);
      row_wall(2304, 0, 2304, 256, 0, CAUSE_NONE);
      row_wall(2147483647, -2147483648, -2147483648, 2147483647, 0, CAUSE_NONE);
      row_wall(2147483647, 2147483647, 2147483647, 2147483647, 0, CAUSE_NONE);
      row_wall(-2147483648, -2147483648, -2147483648, -2147483648, 0, CAUSE_NONE);
      // Shrinking saturates; the box stays inverted.
      row_cfg(REG_BOX_MIN_X, 32'h7fffffff);
      row_cfg(REG_BOX_MIN_Y, 32'h7fffffff);
      row_cfg(REG_BOX_MAX_X, 32'h80000000);
      row_cfg(REG_BOX_MAX_Y, 32'h80000000);
      row_cfg(REG_WALL_THICK, 32'h7fffffff);
      row_wall(0, 0, 0, 0, 1, CAUSE_BAND);
      row_wall(-2147483648, 0, 2147483647, 0, 0, CAUSE_NONE);
      row_wall(0, -2147483648, 5, 2147483647, 0, CAUSE_NONE);
      row_wall(-2147483648, -2147483648, 2147483647, 2147483647, 0, CAUSE_NONE);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            req_valid <= 1'b0;
            wait_drained();
            csr_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
         end else begin
            send_wall(dir_rows[i].wall, dir_rows[i].has_exp, dir_rows[i].exp);
         end
      end

      for (int blk = 0; blk < N_BLOCKS; blk++) begin
         if (blk == N_BLOCKS / 3) begin
            tx_idle_pct = 57;
            rx_idle_pct = 31;
         end else if (blk == 2 * N_BLOCKS / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         // Every block boundary is a full pause until all results are back.
         req_valid <= 1'b0;
         wait_drained();
         bx = near_coord(0, 1 << 20);
         by = near_coord(0, 1 << 20);
         sz = $urandom_range(4096, 16);
         wt = $urandom_range(2048);
         if (blk % 4 == 3)
            box_write($urandom_range(1) ? 32'h7fffffff : 32'h80000000,
                      $urandom_range(1) ? 32'h7fffffff : 32'h80000000,
                      $urandom_range(1) ? 32'h7fffffff : 32'h80000000,
                      $urandom_range(1) ? 32'h7fffffff : 32'h80000000,
                      $urandom_range(1) ? 32'h7fffffff : 32'h0);
         else
            box_write(bx, by, bx + int'($urandom_range(sz)), by + int'($urandom_range(sz)),
                      (blk % 5 == 1) ? 32'h0 : wt);
         span = 2 * sz + wt + 512;
         for (int n = 0; n < BLOCK_LEN; n++) begin
            if ($urandom_range(99) < 20) begin
               w = {$urandom, $urandom, $urandom, $urandom};
            end else begin
               w.start_x = near_coord(bx, span);
               w.start_y = near_coord(by, span);
               if ($urandom_range(9) == 0) begin
                  w.end_x = w.start_x;
                  w.end_y = $urandom_range(1) ? w.start_y : near_coord(by, span);
               end else begin
                  w.end_x = near_coord(bx, span);
                  w.end_y = near_coord(by, span);
               end
            end
            send_wall(w, 0, none);
         end
      end
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);

      $display("%0d walls sent, %0d results checked: %0d crossings, %0d band hits",
               walls_sent, results_seen, cross_seen, band_seen);
      $display("box settings included inverted, saturated and zero-thickness cases");
      if (fails == 0)
         $display("wall_segment_box_collision: match");
      else
         $display("wall_segment_box_collision: mismatch");
      $finish;
   end

endmodule
